// File: design/fpr_pkg.sv
// Shared types for the false-position polynomial root block.
`default_nettype none
package fpr_pkg;

  // Main sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_EV_WAIT,
    S_EV_LOAD,
    S_EV_MUL,
    S_EV_ADD,
    S_EST_MUL,
    S_EST_DIV,
    S_EST_FIN,
    S_UPD,
    S_ERR_MUL,
    S_ERR_DIV,
    S_COMMIT,
    S_OUT
  } state_t;

  // Which point the Horner evaluator works on.
  typedef enum logic [1:0] {
    EV_LO,
    EV_HI,
    EV_ROOT
  } ev_sel_t;

  // Input kinds carried on tuser.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  // Percent scale times the Q16.16 one: 100 * 65536.
  localparam logic [31:0] PCT_Q16 = 32'd6553600;
  localparam logic [30:0] ERR_MAX = 31'h7FFF_FFFF;

endpackage
`default_nettype wire

// File: design/fpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/false_position_poly_root.sv
// Top level: regula falsi polynomial root search in signed Q16.16.
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | in_tdata, in_tuser (mode)
//  out_    | out | out_tvalid/out_tready | out_tdata, out_tuser (flags), out_tlast
//  cfg_    | in  | cfg_we                | cfg_wdata (poly_degree)
//
// Each iteration of a run takes three Horner evaluations on the shared multiplier,
// up to two restoring divisions and some control states.
// Reset (rst_n low, synchronous) clears control state; coefficients are not cleared.
// A row waits in the output register until taken; the run stalls meanwhile.
`default_nettype none
module false_position_poly_root #(
  parameter int MAX_TERMS      = 32,
  parameter int MAX_ITERATIONS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [4:0] coef_index, [36:5] coef_value, [68:37] lower_start,
  // [100:69] upper_start, [107:101] iteration_count, [111:108] zero
  input  wire logic [111:0] in_tdata,
  // [0] mode
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [6:0] iteration_number, [38:7] lower_bound, [70:39] upper_bound,
  // [102:71] root_estimate, [133:103] rel_error_pct, [135:134] zero
  output logic [135:0]      out_tdata,
  // [0] error_valid, [1] divide_fault
  output logic [1:0]        out_tuser,
  output logic              out_tlast,
  input  wire logic         cfg_we,
  input  wire logic [4:0]   cfg_wdata
);

  localparam int AW = $clog2(MAX_TERMS);
  localparam logic [6:0] TERMS_W = 7'(MAX_TERMS);
  localparam logic [6:0] MAXDEG_W = 7'(MAX_TERMS - 1);
  localparam logic [6:0] MAXIT_W = 7'(MAX_ITERATIONS);

  // Magnitude of a signed 32-bit value.
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Saturate a 34-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) begin
      sat34 = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      sat34 = 32'sh8000_0000;
    end else begin
      sat34 = v[31:0];
    end
  endfunction

  fpr_pkg::state_t  state_r, state_nxt;
  fpr_pkg::ev_sel_t ev_sel_r;

  logic [4:0]          degree_r;
  logic [6:0]          cnt_r, k_r;
  logic [AW-1:0]       idx_r;
  logic signed [31:0]  lower_r, upper_r, acc_r, fxl_r, fxu_r, fxr_r, xr_r, old_r;
  logic [63:0]         prod_r, dvd_r;
  logic [31:0]         dvs_r, rem_r;
  logic [5:0]          div_cnt_r;
  logic                neg_r, qzero_r, fault_r, upd_hi_r, upd_lo_r, oldz_r;
  logic [30:0]         err_r;
  logic [135:0]        out_data_r;
  logic [1:0]          out_user_r;
  logic                out_last_r;

  // Coefficient store.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [31:0]         ram_rdata;
  logic                in_acc, out_acc;

  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign ram_we    = in_acc && (in_tuser[0] == fpr_pkg::MODE_LOAD)
                     && ({2'b00, in_tdata[4:0]} < TERMS_W);
  assign ram_waddr = AW'(in_tdata[4:0]);

  fpr_ram #(.WIDTH(32), .DEPTH(MAX_TERMS)) u_coef (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata[36:5]),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Degree in use, clamped to the store size.
  logic [AW-1:0] deg_c;
  assign deg_c = ({2'b00, degree_r} > MAXDEG_W) ? AW'(MAXDEG_W) : AW'(degree_r);

  // Point under evaluation.
  logic signed [31:0] ev_x;
  always_comb begin
    case (ev_sel_r)
      fpr_pkg::EV_LO: ev_x = lower_r;
      fpr_pkg::EV_HI: ev_x = upper_r;
      default:        ev_x = xr_r;
    endcase
  end

  // Differences for the estimate and the error.
  logic signed [32:0] d_c, den_c, ediff_c;
  assign d_c     = 33'(lower_r) - 33'(upper_r);
  assign den_c   = 33'(fxl_r) - 33'(fxu_r);
  assign ediff_c = 33'(old_r) - 33'(xr_r);

  // Shared 32x32 unsigned multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    case (state_r)
      fpr_pkg::S_EST_MUL: begin
        mul_a = mag32(fxu_r);
        mul_b = d_c[32] ? 32'(-d_c) : d_c[31:0];
      end
      fpr_pkg::S_ERR_MUL: begin
        mul_a = ediff_c[32] ? 32'(-ediff_c) : ediff_c[31:0];
        mul_b = fpr_pkg::PCT_Q16;
      end
      default: begin
        mul_a = mag32(acc_r);
        mul_b = mag32(ev_x);
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Horner step: truncated, saturated product plus the next coefficient.
  logic [47:0]        pm_c;
  logic               pneg_c;
  logic signed [32:0] pv_c;
  logic signed [31:0] horner_c;
  assign pm_c   = prod_r[63:16];
  assign pneg_c = neg_r;
  always_comb begin
    if (!pneg_c) begin
      pv_c = (pm_c[47:31] != '0) ? 33'sh0_7FFF_FFFF : $signed({1'b0, pm_c[31:0]});
    end else begin
      pv_c = (pm_c > 48'h0000_8000_0000) ? -33'sh0_8000_0000
                                         : -$signed({1'b0, pm_c[31:0]});
    end
  end
  assign horner_c = sat34(34'(pv_c) + 34'($signed(ram_rdata)));

  // One restoring division step.
  logic [32:0] dtry_c;
  logic        dge_c;
  assign dtry_c = {rem_r, dvd_r[63]};
  assign dge_c  = dtry_c >= {1'b0, dvs_r};

  // Estimate from the quotient, capped and saturated.
  logic [40:0]        qm_c;
  logic signed [42:0] xr_sum_c;
  logic signed [31:0] xr_c;
  assign qm_c = qzero_r ? 41'd0 : ((dvd_r[63:41] != '0) ? 41'h100_0000_0000 : dvd_r[40:0]);
  assign xr_sum_c = neg_r ? 43'(upper_r) + 43'(qm_c) : 43'(upper_r) - 43'(qm_c);
  always_comb begin
    if (xr_sum_c > 43'sh7FFF_FFFF) begin
      xr_c = 32'sh7FFF_FFFF;
    end else if (xr_sum_c < -43'sh8000_0000) begin
      xr_c = 32'sh8000_0000;
    end else begin
      xr_c = xr_sum_c[31:0];
    end
  end

  // Sign test of p(xl) * p(xr).
  logic pz_c, pneg_prod_c;
  assign pz_c        = (fxl_r == 0) || (fxr_r == 0);
  assign pneg_prod_c = fxl_r[31] != fxr_r[31];

  logic ev_done_c;
  assign ev_done_c = idx_r == '0;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fpr_pkg::S_IDLE: begin
        if (in_acc && (in_tuser[0] == fpr_pkg::MODE_RUN) && (in_tdata[107:101] != 7'd0)) begin
          state_nxt = fpr_pkg::S_EV_WAIT;
        end
      end
      fpr_pkg::S_EV_WAIT: state_nxt = fpr_pkg::S_EV_LOAD;
      fpr_pkg::S_EV_LOAD, fpr_pkg::S_EV_ADD: begin
        if (!ev_done_c) begin
          state_nxt = fpr_pkg::S_EV_MUL;
        end else begin
          case (ev_sel_r)
            fpr_pkg::EV_LO: state_nxt = fpr_pkg::S_EV_WAIT;
            fpr_pkg::EV_HI: state_nxt = fpr_pkg::S_EST_MUL;
            default:        state_nxt = fpr_pkg::S_UPD;
          endcase
        end
      end
      fpr_pkg::S_EV_MUL: state_nxt = fpr_pkg::S_EV_ADD;
      fpr_pkg::S_EST_MUL: begin
        state_nxt = (den_c == 0) ? fpr_pkg::S_EST_FIN : fpr_pkg::S_EST_DIV;
      end
      fpr_pkg::S_EST_DIV: begin
        if (div_cnt_r == 6'd63) state_nxt = fpr_pkg::S_EST_FIN;
      end
      fpr_pkg::S_EST_FIN: state_nxt = fpr_pkg::S_EV_WAIT;
      fpr_pkg::S_UPD: begin
        if (pz_c) begin
          state_nxt = fpr_pkg::S_COMMIT;
        end else if ((pneg_prod_c ? upper_r : lower_r) == 0) begin
          state_nxt = fpr_pkg::S_COMMIT;
        end else begin
          state_nxt = fpr_pkg::S_ERR_MUL;
        end
      end
      fpr_pkg::S_ERR_MUL: state_nxt = fpr_pkg::S_ERR_DIV;
      fpr_pkg::S_ERR_DIV: begin
        if (div_cnt_r == 6'd63) state_nxt = fpr_pkg::S_COMMIT;
      end
      fpr_pkg::S_COMMIT: state_nxt = fpr_pkg::S_OUT;
      fpr_pkg::S_OUT: begin
        if (out_acc) begin
          state_nxt = (k_r + 7'd1 == cnt_r) ? fpr_pkg::S_IDLE : fpr_pkg::S_EV_WAIT;
        end
      end
      default: state_nxt = fpr_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_tready  = state_r == fpr_pkg::S_IDLE;
    out_tvalid = state_r == fpr_pkg::S_OUT;
    out_tdata  = out_data_r;
    out_tuser  = out_user_r;
    out_tlast  = out_last_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fpr_pkg::S_IDLE;
      degree_r <= 5'd1;
      ev_sel_r <= fpr_pkg::EV_LO;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        degree_r <= cfg_wdata;
      end
      // Evaluation target follows the iteration's three points.
      if (state_nxt == fpr_pkg::S_EV_WAIT) begin
        case (state_r)
          fpr_pkg::S_EV_LOAD, fpr_pkg::S_EV_ADD: ev_sel_r <= fpr_pkg::EV_HI;
          fpr_pkg::S_EST_FIN:                    ev_sel_r <= fpr_pkg::EV_ROOT;
          default:                               ev_sel_r <= fpr_pkg::EV_LO;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_nxt == fpr_pkg::S_EV_WAIT) begin
      idx_r <= deg_c;
    end
    case (state_r)
      fpr_pkg::S_IDLE: begin
        if (in_acc && (in_tuser[0] == fpr_pkg::MODE_RUN)) begin
          lower_r <= in_tdata[68:37];
          upper_r <= in_tdata[100:69];
          err_r   <= '0;
          cnt_r   <= (in_tdata[107:101] > MAXIT_W) ? MAXIT_W : in_tdata[107:101];
          k_r     <= '0;
          fault_r <= 1'b0;
        end
      end
      fpr_pkg::S_EV_LOAD, fpr_pkg::S_EV_ADD: begin
        logic signed [31:0] v;
        v = (state_r == fpr_pkg::S_EV_LOAD) ? ram_rdata : horner_c;
        acc_r <= v;
        if (!ev_done_c) begin
          idx_r <= idx_r - AW'(1);
        end else begin
          case (ev_sel_r)
            fpr_pkg::EV_LO: fxl_r <= v;
            fpr_pkg::EV_HI: fxu_r <= v;
            default:        fxr_r <= v;
          endcase
        end
      end
      fpr_pkg::S_EV_MUL: begin
        prod_r <= mul_p;
        neg_r  <= acc_r[31] != ev_x[31];
      end
      fpr_pkg::S_EST_MUL: begin
        dvd_r     <= mul_p;
        dvs_r     <= den_c[32] ? 32'(-den_c) : den_c[31:0];
        rem_r     <= '0;
        div_cnt_r <= '0;
        neg_r     <= (fxu_r[31] != d_c[32]) != den_c[32];
        qzero_r   <= den_c == 0;
        if (den_c == 0) fault_r <= 1'b1;
      end
      fpr_pkg::S_EST_DIV, fpr_pkg::S_ERR_DIV: begin
        rem_r     <= dge_c ? 32'(dtry_c - {1'b0, dvs_r}) : dtry_c[31:0];
        dvd_r     <= {dvd_r[62:0], dge_c};
        div_cnt_r <= div_cnt_r + 6'd1;
      end
      fpr_pkg::S_EST_FIN: begin
        xr_r <= xr_c;
      end
      fpr_pkg::S_UPD: begin
        upd_hi_r <= !pz_c && pneg_prod_c;
        upd_lo_r <= !pz_c && !pneg_prod_c;
        old_r    <= pneg_prod_c ? upper_r : lower_r;
        oldz_r   <= (pneg_prod_c ? upper_r : lower_r) == 0;
        if (!pz_c && ((pneg_prod_c ? upper_r : lower_r) == 0)) fault_r <= 1'b1;
      end
      fpr_pkg::S_ERR_MUL: begin
        dvd_r     <= mul_p;
        dvs_r     <= mag32(old_r);
        rem_r     <= '0;
        div_cnt_r <= '0;
      end
      fpr_pkg::S_COMMIT: begin
        logic signed [31:0] lo_n, hi_n;
        logic [30:0]        err_n;
        lo_n  = upd_lo_r ? xr_r : lower_r;
        hi_n  = upd_hi_r ? xr_r : upper_r;
        err_n = err_r;
        if (upd_lo_r || upd_hi_r) begin
          err_n = oldz_r ? fpr_pkg::ERR_MAX
                         : ((dvd_r[63:31] != '0) ? fpr_pkg::ERR_MAX : dvd_r[30:0]);
        end
        lower_r <= lo_n;
        upper_r <= hi_n;
        err_r   <= err_n;
        if (k_r == 7'd0) begin
          out_data_r <= {2'b00, 31'd0, xr_r, upper_r, lower_r, 7'd1};
        end else begin
          out_data_r <= {2'b00, err_n, xr_r, hi_n, lo_n, k_r + 7'd1};
        end
        out_user_r <= {fault_r, k_r != 7'd0};
        out_last_r <= k_r + 7'd1 == cnt_r;
      end
      fpr_pkg::S_OUT: begin
        if (out_acc) begin
          k_r     <= k_r + 7'd1;
          fault_r <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sim/false_position_poly_root_test.sv
// Testbench for the false-position polynomial root block with a predicting scoreboard.
`default_nettype none

// Expected or observed content of one result transaction.
typedef struct packed {
  logic [6:0]  iter_num;
  logic [31:0] lower;
  logic [31:0] upper;
  logic [31:0] root;
  logic [30:0] err_pct;
  logic        err_valid;
  logic        div_fault;
  logic        last;
} fpr_row_t;

// Predicts the rows of each search and checks the rows that come out.
class fpr_scoreboard;
  int          coef[32];
  int unsigned degree;
  int          lower_end;
  int          upper_end;
  int unsigned err_reg;
  fpr_row_t    pending_rows[$];
  int          mismatches;

  function new();
    degree     = 1;
    mismatches = 0;
    lower_end  = 0;
    upper_end  = 0;
    err_reg    = 0;
    foreach (coef[i]) coef[i] = 0;
  endfunction

  function longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function int sat32(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // Clamp the magnitude and apply the sign.
  function longint signed_mag(longint unsigned m, bit neg);
    if (m > (64'd1 << 40)) m = 64'd1 << 40;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function int fix_mul(int a, int b);
    longint unsigned m;
    m = (mag(a) * mag(b)) >> 16;
    return sat32(signed_mag(m, (a < 0) != (b < 0)));
  endfunction

  // Horner evaluation of the loaded polynomial.
  function int poly_at(int x);
    int acc;
    acc = coef[degree];
    for (int i = degree; i > 0; i--)
      acc = sat32(longint'(fix_mul(acc, x)) + coef[i-1]);
    return acc;
  endfunction

  function int unsigned pct_err(int old_end, int xr, ref bit fault);
    longint unsigned q;
    if (old_end == 0) begin
      fault = 1;
      return fpr_pkg::ERR_MAX;
    end
    q = (mag(longint'(old_end) - xr) * 64'd6553600) / mag(old_end);
    return (q > fpr_pkg::ERR_MAX) ? fpr_pkg::ERR_MAX : int'(q);
  endfunction

  function void set_degree(logic [4:0] d);
    degree = d;
  endfunction

  // Note an accepted input transaction and queue the rows it causes.
  function void note_input(logic mode, logic [4:0] idx, int value, int lo, int up,
                           logic [6:0] count);
    int       xl, xu, fxl, fxu, xr, fxr, prod;
    longint   d, den, q;
    bit       fault;
    fpr_row_t row;
    if (mode == fpr_pkg::MODE_LOAD) begin
      coef[idx] = value;
      return;
    end
    lower_end = lo;
    upper_end = up;
    err_reg   = 0;
    if (count > 64) count = 64;
    for (int k = 0; k < count; k++) begin
      xl    = lower_end;
      xu    = upper_end;
      fxl   = poly_at(xl);
      fxu   = poly_at(xu);
      d     = longint'(xl) - xu;
      den   = longint'(fxl) - fxu;
      fault = 0;
      q     = 0;
      if (den == 0) fault = 1;
      else q = signed_mag((mag(fxu) * mag(d)) / mag(den),
                          ((fxu < 0) != (d < 0)) != (den < 0));
      xr   = sat32(longint'(xu) - q);
      fxr  = poly_at(xr);
      prod = ((fxl > 0) ? 1 : (fxl < 0) ? -1 : 0) * ((fxr > 0) ? 1 : (fxr < 0) ? -1 : 0);
      row.iter_num = k + 1;
      row.lower    = xl;
      row.upper    = xu;
      if (prod < 0) begin
        err_reg   = pct_err(xu, xr, fault);
        upper_end = xr;
      end else if (prod > 0) begin
        err_reg   = pct_err(xl, xr, fault);
        lower_end = xr;
      end
      if (k != 0) begin
        row.lower = lower_end;
        row.upper = upper_end;
      end
      row.root      = xr;
      row.err_pct   = (k == 0) ? 31'd0 : err_reg[30:0];
      row.err_valid = (k != 0);
      row.div_fault = fault;
      row.last      = (k + 1 == count);
      pending_rows.push_back(row);
    end
  endfunction

  // Compare one result transaction with the oldest expected row.
  function void check_row(fpr_row_t got);
    fpr_row_t exp_row;
    if (pending_rows.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected row: iter %0d", got.iter_num);
      return;
    end
    exp_row = pending_rows.pop_front();
    if (got !== exp_row) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Row mismatch: exp %0d %h %h %h %h %b%b%b got %0d %h %h %h %h %b%b%b",
                 exp_row.iter_num, exp_row.lower, exp_row.upper, exp_row.root,
                 exp_row.err_pct, exp_row.err_valid, exp_row.div_fault, exp_row.last,
                 got.iter_num, got.lower, got.upper, got.root, got.err_pct,
                 got.err_valid, got.div_fault, got.last);
    end
  endfunction
endclass

module false_position_poly_root_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int ONE = 65536;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_we;
  logic [4:0]   cfg_wdata;

  fpr_scoreboard sb;
  bit            no_idle;
  int            cycles;

  false_position_poly_root u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Cycle counter with a hard stop.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random back-pressure, check every accepted row.
  always @(posedge clk) begin
    fpr_row_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.iter_num  = out_tdata[6:0];
      got.lower     = out_tdata[38:7];
      got.upper     = out_tdata[70:39];
      got.root      = out_tdata[102:71];
      got.err_pct   = out_tdata[133:103];
      got.err_valid = out_tuser[0];
      got.div_fault = out_tuser[1];
      got.last      = out_tlast;
      sb.check_row(got);
    end
    out_tready <= no_idle || ($urandom_range(99) >= 10);
  end

  // Drive one input transaction and wait for its acceptance. The valid
  // stays up so that a following transaction can start at once.
  task automatic send(logic mode, logic [4:0] idx, int value, int lo, int up,
                      logic [6:0] count);
    while (!no_idle && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {4'b0, count, up, lo, value, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_input(mode, idx, value, lo, up, count);
  endtask

  task automatic load(logic [4:0] idx, int value);
    send(fpr_pkg::MODE_LOAD, idx, value, 0, 0, 7'd0);
  endtask

  task automatic search(int lo, int up, logic [6:0] count);
    send(fpr_pkg::MODE_RUN, 5'd0, 0, lo, up, count);
  endtask

  // Drop the input valid, wait until every expected row has come, then let
  // the block settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_degree(logic [4:0] d);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    sb.set_degree(d);
    cfg_we    <= 1'b0;
  endtask

  function automatic int small_fix();
    return $signed($urandom_range(8 * ONE)) - 4 * ONE;
  endfunction

  // One random transaction: mostly loads of small values and short searches.
  task automatic random_item();
    int lo, up;
    logic [6:0] count;
    if ($urandom_range(99) < 45) begin
      load($urandom_range(31), ($urandom_range(9) == 0) ? int'($urandom) : small_fix());
    end else begin
      lo    = ($urandom_range(9) == 0) ? int'($urandom) : small_fix() * 2;
      up    = ($urandom_range(9) == 0) ? int'($urandom) : small_fix() * 2;
      count = ($urandom_range(19) == 0) ? 7'($urandom_range(64)) : 7'($urandom_range(1, 6));
      if (count == 0) count = 1;
      search(lo, up, count);
    end
  endtask

  initial begin
    sb         = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    no_idle    = 0;
    cycles     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every coefficient is written before any search reads it.
    for (int i = 0; i < 32; i++) load(i, (i < 2) ? ((i == 0) ? -2 * ONE : ONE) : 0);

    // Directed part at the reset degree: x - 2 on a good bracket, extremes.
    search(0, 4 * ONE, 7'd5);
    search(32'sh8000_0000, 32'sh7FFF_FFFF, 7'd3);
    search(2 * ONE, 2 * ONE, 7'd2);            // equal ends: zero estimate divisor
    search(0, 0, 7'd2);                         // zero ends
    search(2 * ONE, 5 * ONE, 7'd2);             // root at the lower end: zero product
    load(5'd31, 32'sh7FFF_FFFF);
    load(5'd30, 32'sh8000_0000);
    load(5'd2, -ONE);
    load(5'd1, 0);
    load(5'd0, 4 * ONE);
    set_degree(5'd0);                           // constant: always a zero divisor
    search(-ONE, ONE, 7'd2);
    set_degree(5'd2);                           // 4 - x^2, root at 2
    search(0, 3 * ONE, 7'd64);
    search(-3 * ONE, ONE, 7'd8);
    set_degree(5'd31);                          // full degree with saturating terms
    search(-ONE / 2, ONE / 2, 7'd3);
    search(32'sh8000_0000, 32'sh7FFF_FFFF, 7'd1);

    // Random part over several degree settings; the middle phase never idles.
    for (int ph = 0; ph < 5; ph++) begin
      set_degree((ph == 4) ? 5'd31 : 5'($urandom_range(1, 4)));
      no_idle = (ph == 2);
      for (int n = 0; n < 12; n++) random_item();
    end
    no_idle = 0;

    drain();
    repeat (400) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_rows.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

`default_nettype wire

// File: false_position_poly_root.f
design/fpr_pkg.sv
design/fpr_ram.sv
design/false_position_poly_root.sv
sim/false_position_poly_root_test.sv
